/* sv/sbq_pkg.sv */
package sbq_pkg;

   localparam int DEFAULT_CHANNELS = 2;

   localparam int SAMPLE_W   = 24;
   localparam int COEFF_W    = 32;
   localparam int TAPSUM_W   = SAMPLE_W + 3;
   localparam int ACC_W      = 60;
   localparam int FRAC_SHIFT = 29;
   localparam int QUOT_W     = ACC_W - FRAC_SHIFT;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COEFF_W;

   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_A0      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_B1      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_B2      = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (FRAC_SHIFT - 1));

   typedef struct packed {
      logic                      filter_enable;
      logic signed [COEFF_W-1:0] coeff_a0;
      logic signed [COEFF_W-1:0] coeff_b1;
      logic signed [COEFF_W-1:0] coeff_b2;
   } sbq_coeff_type;

endpackage

/* sv/sbq_lane.sv */
module sbq_lane (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  sbq_pkg::sbq_coeff_type                  coeff,
   input  logic signed [sbq_pkg::SAMPLE_W-1:0]     sample_in,
   output logic signed [sbq_pkg::SAMPLE_W-1:0]     filtered_out
);

   logic signed [sbq_pkg::SAMPLE_W-1:0] x1_ff, x1_in;
   logic signed [sbq_pkg::SAMPLE_W-1:0] x2_ff, x2_in;
   logic signed [sbq_pkg::SAMPLE_W-1:0] y1_ff, y1_in;
   logic signed [sbq_pkg::SAMPLE_W-1:0] y2_ff, y2_in;

   logic signed [sbq_pkg::SAMPLE_W-1:0] x1_eff, x2_eff, y1_eff, y2_eff;
   logic signed [sbq_pkg::TAPSUM_W-1:0] tap_sum;
   logic signed [sbq_pkg::ACC_W-1:0]    prod_a, prod_b1, prod_b2;
   logic signed [sbq_pkg::ACC_W-1:0]    acc;
   logic signed [sbq_pkg::QUOT_W-1:0]   quot;
   logic                                in_range;
   logic signed [sbq_pkg::SAMPLE_W-1:0] y_sat;

   // disabled filter sees empty history
   assign x1_eff = coeff.filter_enable ? x1_ff : '0;
   assign x2_eff = coeff.filter_enable ? x2_ff : '0;
   assign y1_eff = coeff.filter_enable ? y1_ff : '0;
   assign y2_eff = coeff.filter_enable ? y2_ff : '0;

   // a0 taps share one product: a0 * (x0 + 2*x1 + x2)
   assign tap_sum = sbq_pkg::TAPSUM_W'(sample_in)
                  + (sbq_pkg::TAPSUM_W'(x1_eff) <<< 1)
                  + sbq_pkg::TAPSUM_W'(x2_eff);

   always_comb begin
      prod_a  = coeff.coeff_a0 * tap_sum;
      prod_b1 = coeff.coeff_b1 * y1_eff;
      prod_b2 = coeff.coeff_b2 * y2_eff;
      acc     = prod_a - prod_b1 - prod_b2 + sbq_pkg::ROUND_HALF;
      quot    = acc[sbq_pkg::ACC_W-1:sbq_pkg::FRAC_SHIFT];
      in_range = (&quot[sbq_pkg::QUOT_W-1:sbq_pkg::SAMPLE_W-1])
              || (~|quot[sbq_pkg::QUOT_W-1:sbq_pkg::SAMPLE_W-1]);
      if (in_range) begin
         y_sat = quot[sbq_pkg::SAMPLE_W-1:0];
      end else if (quot[sbq_pkg::QUOT_W-1]) begin
         y_sat = sbq_pkg::SAMPLE_MIN;
      end else begin
         y_sat = sbq_pkg::SAMPLE_MAX;
      end
   end

   assign filtered_out = y_sat;

   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      if (step) begin
         x1_in = sample_in;
         x2_in = x1_eff;
         y1_in = y_sat;
         y2_in = y1_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

endmodule

/* sv/stereo_biquad_filter.sv */
// stereo_biquad_filter: per-channel second-order direct form I filter
//
// req channel: one frame per beat, CHANNELS samples of 24 bit Q1.23 in
//   req_tdata, channel 0 in the lowest bits.
// rsp channel: one filtered frame per beat, same packing, saturated to
//   24 bits and rounded to nearest.
// csr port: csr_we writes csr_wdata into register csr_index at the clock
//   edge (0 enable, 1 a0, 2 b1, 3 b2); write only while the block is idle.
// Each accepted frame is registered into the result buffer, in order.
// Throughput: one frame per cycle while req_tready is high. Each channel
//   lane computes its three products, the sum, rounding and saturation
//   combinationally, since the new output feeds back into the next sum.
// A two-beat result buffer decouples the sides: req_tready stays high
//   while at most one result waits, so a stalled receiver holds two
//   frames before input stalls.
// Reset (synchronous, active high) clears history, registers and the
//   result buffer; the first frame may be sent in the next cycle.
module stereo_biquad_filter #(
   parameter int CHANNELS = sbq_pkg::DEFAULT_CHANNELS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_ch0, sample_ch1, ... from bit 0 up
   input  logic [CHANNELS*sbq_pkg::SAMPLE_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // filtered_ch0, filtered_ch1, ... from bit 0 up
   output logic [CHANNELS*sbq_pkg::SAMPLE_W-1:0] rsp_tdata,
   input  logic                                csr_we,
   input  logic [sbq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sbq_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int FRAME_W = CHANNELS * sbq_pkg::SAMPLE_W;

   sbq_pkg::sbq_coeff_type coeff_ff, coeff_in;

   logic               push, pop;
   logic [1:0]         count_ff, count_in;
   logic [FRAME_W-1:0] slot0_ff, slot0_in;
   logic [FRAME_W-1:0] slot1_ff, slot1_in;
   logic [FRAME_W-1:0] frame_out;

   always_comb begin
      coeff_in = coeff_ff;
      if (csr_we) begin
         unique case (csr_index)
            sbq_pkg::REG_FILTER_ENABLE: coeff_in.filter_enable = csr_wdata[0];
            sbq_pkg::REG_COEFF_A0:      coeff_in.coeff_a0 = csr_wdata;
            sbq_pkg::REG_COEFF_B1:      coeff_in.coeff_b1 = csr_wdata;
            sbq_pkg::REG_COEFF_B2:      coeff_in.coeff_b2 = csr_wdata;
            default:                    coeff_in = coeff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = slot0_ff;

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      sbq_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .step         (push),
         .coeff        (coeff_ff),
         .sample_in    (req_tdata[ch*sbq_pkg::SAMPLE_W +: sbq_pkg::SAMPLE_W]),
         .filtered_out (frame_out[ch*sbq_pkg::SAMPLE_W +: sbq_pkg::SAMPLE_W])
      );
   end

   // merge lanes into a frame and queue it
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) begin
            slot0_in = frame_out;
         end else begin
            slot1_in = frame_out;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTH
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_push_shows : assert property (@(posedge clock) disable iff (reset)
      (push && !rsp_tvalid) |=> rsp_tvalid)
      else $error("accepted frame not presented");

   a_pop_only : assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("result buffer lost track on pop");
`endif

endmodule
